// ----- hdl/dfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfl_pkg: shared types and constants of the deduplicating event log
// sizes, operation and status codes, register indexes, word structs
// ----------------------------------------------------------------------------
package dfl_pkg;

  localparam int SLOTS      = 256;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRUSTED = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FILT_CLS  = 3'd2,
    STAT_FILT_TRST = 3'd3,
    STAT_DISARMED  = 3'd4,
    STAT_READ_OK   = 3'd5,
    STAT_READ_OOR  = 3'd6,
    STAT_CLEARED   = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RDREQ,
    S_RDWAIT,
    S_DONE
  } state_e;

  // one log entry as stored in the ram
  typedef struct packed {
    logic [7:0]  cls;
    logic [63:0] addr;
    logic [63:0] key;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] addr;
    logic [7:0]  cls;
    logic        trusted;
    logic [7:0]  pos;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [63:0]      key;
    logic [63:0]      addr;
    logic [7:0]       cls;
    logic [CNT_W-1:0] occupied;
  } res_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] trusted_code;
    logic       arm_clr;
  } cfg_t;

endpackage

// ----- hdl/dfl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfl_ram: generic single-port ram
// one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module dfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- hdl/dfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfl_ctrl: sequencer of the event log
// filters, scans slots through one key/address comparator, writes and reads
// ----------------------------------------------------------------------------
module dfl_ctrl
  import dfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_i,
  input  cfg_t              cfg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic              ram_we_o,
  output logic [SLOT_W-1:0] ram_addr_o,
  output slot_t             ram_wdata_o,
  input  slot_t             ram_rdata_i
);

  state_e            state_q, state_d;
  slot_t             slot_q, slot_d;
  logic [7:0]        pos_q, pos_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              filtered;
  logic              in_range;
  logic              hit;
  logic              full;
  logic [SLOT_W:0]   rd_sum;
  logic [SLOT_W-1:0] rd_idx;

  assign accept   = in_valid_i && in_ready_o;
  assign full     = (count_q == CNT_W'(SLOTS));
  assign filtered = !cfg_i.enable || (in_i.cls == cfg_i.trusted_code) || in_i.trusted;
  assign in_range = (32'(in_i.pos) < 32'(count_q));

  // the shared comparator
  assign hit = (ram_rdata_i.key == slot_q.key) && (ram_rdata_i.addr == slot_q.addr);

  // oldest-first position to physical slot
  assign rd_sum = (full ? {1'b0, head_q} : '0) + (SLOT_W + 1)'(pos_q);
  assign rd_idx = (rd_sum >= (SLOT_W + 1)'(SLOTS)) ?
                  SLOT_W'(rd_sum - (SLOT_W + 1)'(SLOTS)) : SLOT_W'(rd_sum);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          priority if (in_i.op == OP_RECORD) begin
            if (filtered) begin
              state_d = S_DONE;
            end else if (count_q == '0) begin
              state_d = S_WRITE;
            end else begin
              state_d = S_SCAN;
            end
          end else if (in_i.op == OP_READ) begin
            state_d = in_range ? S_RDREQ : S_DONE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_q && hit) begin
          state_d = S_DONE;
        end else if ((scan_q == count_q) && !cmp_vld_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE:  state_d = S_DONE;
      S_RDREQ:  state_d = S_RDWAIT;
      S_RDWAIT: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    slot_d      = slot_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    cmp_vld_d   = 1'b0;
    head_d      = head_q;
    count_d     = count_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = head_q;
    ram_wdata_o = slot_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          slot_d = '{cls: in_i.cls, addr: in_i.addr, key: in_i.key};
          pos_d  = in_i.pos;
          scan_d = '0;
          res_d  = '0;
          priority if (in_i.op == OP_RECORD) begin
            priority if (!cfg_i.enable) begin
              res_d.status = STAT_DISARMED;
            end else if (in_i.cls == cfg_i.trusted_code) begin
              res_d.status = STAT_FILT_CLS;
            end else if (in_i.trusted) begin
              res_d.status = STAT_FILT_TRST;
            end else begin
              res_d.status = STAT_INSERTED;
            end
          end else if (in_i.op == OP_READ) begin
            res_d.status = in_range ? STAT_READ_OK : STAT_READ_OOR;
          end else if (in_i.op == OP_CLEAR) begin
            res_d.status = STAT_CLEARED;
            head_d       = '0;
            count_d      = '0;
          end else begin
            res_d.status = STAT_DISARMED;
          end
        end
      end
      S_SCAN: begin
        ram_addr_o = scan_q[SLOT_W-1:0];
        if (scan_q < count_q) begin
          cmp_vld_d = 1'b1;
          scan_d    = scan_q + CNT_W'(1);
        end
        if (cmp_vld_q && hit) begin
          res_d.status = STAT_DUPLICATE;
        end
      end
      S_WRITE: begin
        ram_we_o     = 1'b1;
        ram_addr_o   = head_q;
        head_d       = (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
        count_d      = full ? count_q : count_q + CNT_W'(1);
        res_d.status = STAT_INSERTED;
      end
      S_RDREQ: begin
        ram_addr_o = rd_idx;
      end
      S_RDWAIT: begin
        res_d.key  = ram_rdata_i.key;
        res_d.addr = ram_rdata_i.addr;
        res_d.cls  = ram_rdata_i.cls;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase

    // arming the log empties it
    if (cfg_i.arm_clr) begin
      head_d  = '0;
      count_d = '0;
    end
  end

  always_comb begin
    res_o          = res_q;
    res_o.occupied = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      head_q    <= '0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      head_q    <= head_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    pos_q  <= pos_d;
    res_q  <= res_d;
  end

`ifndef SYNTH
  // count saturates at capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("count above capacity");

  // until the log wraps, the head sits right after the newest entry
  a_head_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (CNT_W'(head_q) == count_q))
    else $error("head out of step with count");

  // each insert grows the log by one unless it is full
  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && !cfg_i.arm_clr) |=>
      (count_q == (($past(count_q) == CNT_W'(SLOTS)) ? $past(count_q)
                                                      : $past(count_q) + CNT_W'(1))))
    else $error("count not updated by insert");

  // the scan never runs past the occupied slots
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q <= count_q))
    else $error("scan past occupied slots");
`endif

endmodule

// ----- hdl/dedup_fifo_event_log.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_fifo_event_log: deduplicating circular event log
// records filtered events, rejects repeats, reads oldest-first, clears
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command word: tuser is the op (record, read, clear),
//   tdata the event fields. m_axis returns exactly one result word per
//   command: tuser is the status, tdata the entry read and the fill count.
//   cfg writes the enable bit (index 0) and the trusted region code
//   (index 1); cfg_ready_o is always high. arming the log (enable 0 -> 1)
//   empties it. write config only while no command is in flight.
// timing
//   one command at a time; s_axis_tready_o is high only while the sequencer
//   is idle. filtered records, clears, no-ops and out-of-range reads go
//   straight to the result; reads take one ram read. records write at once
//   on an empty log, else after the duplicate scan that reads one slot per
//   cycle through the single ram port and stops at the first hit.
// reset
//   empty log, disarmed, trusted code zero; no clearing pass is needed.
// stall
//   a result waits in the output register; the next command is still taken
//   and worked on, and its result waits in the sequencer until m_axis frees.
// ----------------------------------------------------------------------------
module dedup_fifo_event_log
  import dfl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // command words
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // name_key[63:0], event_address[127:64], region_class[135:128],
  // in_trusted_code[136], read_position[144:137], zero pad[151:145]
  input  logic [151:0]          s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]            s_axis_tuser_i,
  // result words
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // entry_name_key[63:0], entry_address[127:64], entry_class[135:128],
  // occupied[144:136], zero pad[151:145]
  output logic [151:0]          m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]            m_axis_tuser_o
);

  // config registers
  logic       enable_q;
  logic [7:0] trusted_q;
  logic       cfg_we;
  cfg_t       cfg;

  // sequencer handoff
  in_t        cmd;
  logic       res_valid;
  logic       res_ready;
  res_t       res;

  // slot ram
  logic              ram_we;
  logic [SLOT_W-1:0] ram_addr;
  slot_t             ram_wdata;
  slot_t             ram_rdata;

  // output register
  logic       out_valid_q, out_valid_d;
  res_t       out_q, out_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      trusted_q <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i == REG_ENABLE) begin
        enable_q <= cfg_data_i[0];
      end
      if (cfg_index_i == REG_TRUSTED) begin
        trusted_q <= cfg_data_i[7:0];
      end
    end
  end

  // rising enable empties the log in the same cycle the write lands
  assign cfg.enable       = enable_q;
  assign cfg.trusted_code = trusted_q;
  assign cfg.arm_clr      = cfg_we && (cfg_index_i == REG_ENABLE) &&
                            cfg_data_i[0] && !enable_q;

  // unpack the command word
  assign cmd.op      = s_axis_tuser_i;
  assign cmd.key     = s_axis_tdata_i[63:0];
  assign cmd.addr    = s_axis_tdata_i[127:64];
  assign cmd.cls     = s_axis_tdata_i[135:128];
  assign cmd.trusted = s_axis_tdata_i[136];
  assign cmd.pos     = s_axis_tdata_i[144:137];

  dfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_i        (cmd),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  dfl_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {7'd0, out_q.occupied, out_q.cls, out_q.addr, out_q.key};

endmodule

// ----- tb/sv/dfl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfl_checker: scoreboard for the deduplicating event log
// mirrors the log contents from accepted config and command words, queues
// the expected result of every command and compares each result word
// ----------------------------------------------------------------------------
module dfl_checker
  import dfl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [151:0]          s_tdata_i,
  input  logic [1:0]            s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [151:0]          m_tdata_i,
  input  logic [2:0]            m_tuser_i,
  output int                    errors_o,
  output int                    outstanding_o
);

  localparam int MAX_PRINTED = 40;

  // mirrored log
  logic [63:0]      log_key  [SLOTS];
  logic [63:0]      log_addr [SLOTS];
  logic [7:0]       log_cls  [SLOTS];
  logic [SLOT_W-1:0] log_head;
  logic [CNT_W-1:0] log_count;
  logic             armed;
  logic [7:0]       trusted_code;

  res_t expected_q[$];
  int   err_cnt = 0;
  int   words_seen = 0;
  int   pending = 0;

  assign errors_o      = err_cnt;
  assign outstanding_o = pending;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_cnt < MAX_PRINTED)
      $display("%0t ns: result %0d %s mismatch, got %h want %h",
               $time, words_seen, what, got, want);
    err_cnt++;
  endtask

  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_ENABLE) begin
      // arming empties the log
      if (data[0] && !armed) begin
        log_head  = '0;
        log_count = '0;
      end
      armed = data[0];
    end else if (idx == REG_TRUSTED) begin
      trusted_code = data[7:0];
    end
  endtask

  task automatic log_command(input logic [1:0] op, input logic [63:0] key,
                             input logic [63:0] addr, input logic [7:0] cls,
                             input logic trusted, input logic [7:0] pos);
    res_t r;
    logic hit;
    int   idx;
    r        = '0;
    r.status = STAT_DISARMED;
    case (op)
      OP_RECORD: begin
        if (!armed) begin
          r.status = STAT_DISARMED;
        end else if (cls == trusted_code) begin
          r.status = STAT_FILT_CLS;
        end else if (trusted) begin
          r.status = STAT_FILT_TRST;
        end else begin
          hit = 1'b0;
          for (int i = 0; i < log_count; i++)
            if (log_key[i] == key && log_addr[i] == addr) hit = 1'b1;
          if (hit) begin
            r.status = STAT_DUPLICATE;
          end else begin
            log_key[log_head]  = key;
            log_addr[log_head] = addr;
            log_cls[log_head]  = cls;
            log_head           = log_head + 1'b1;
            if (log_count < SLOTS) log_count = log_count + 1'b1;
            r.status = STAT_INSERTED;
          end
        end
      end
      OP_READ: begin
        if (pos < log_count) begin
          // oldest is slot 0 until full, then the slot at head
          idx    = (log_count < SLOTS) ? 0 : int'(log_head);
          idx    = (idx + int'(pos)) % SLOTS;
          r.key  = log_key[idx];
          r.addr = log_addr[idx];
          r.cls  = log_cls[idx];
          r.status = STAT_READ_OK;
        end else begin
          r.status = STAT_READ_OOR;
        end
      end
      OP_CLEAR: begin
        log_head  = '0;
        log_count = '0;
        r.status  = STAT_CLEARED;
      end
      default: r.status = STAT_DISARMED;
    endcase
    r.occupied = log_count;
    expected_q.push_back(r);
  endtask

  task automatic check_result();
    res_t want;
    words_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected word", {61'd0, m_tuser_i}, '0);
      return;
    end
    want = expected_q.pop_front();
    if (m_tuser_i != want.status)
      report_mismatch("status", {61'd0, m_tuser_i}, {61'd0, want.status});
    if (m_tdata_i[63:0] != want.key)
      report_mismatch("entry_name_key", m_tdata_i[63:0], want.key);
    if (m_tdata_i[127:64] != want.addr)
      report_mismatch("entry_address", m_tdata_i[127:64], want.addr);
    if (m_tdata_i[135:128] != want.cls)
      report_mismatch("entry_class", {56'd0, m_tdata_i[135:128]}, {56'd0, want.cls});
    if (m_tdata_i[144:136] != want.occupied)
      report_mismatch("occupied", {55'd0, m_tdata_i[144:136]}, {55'd0, want.occupied});
    if (m_tdata_i[151:145] != '0)
      report_mismatch("pad bits", {57'd0, m_tdata_i[151:145]}, '0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_head     = '0;
      log_count    = '0;
      armed        = 1'b0;
      trusted_code = '0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_config(cfg_index_i, cfg_data_i);
      if (s_tvalid_i && s_tready_i)
        log_command(s_tuser_i, s_tdata_i[63:0], s_tdata_i[127:64],
                    s_tdata_i[135:128], s_tdata_i[136], s_tdata_i[144:137]);
      if (m_tvalid_i && m_tready_i) check_result();
      pending <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the deduplicating event log
// a directed pass over filters, reads, clears and arming, then random
// phases under several register settings with idle bursts on both streams
// and one long result stall; dfl_checker does all the comparing
// ----------------------------------------------------------------------------
module testbench
  import dfl_pkg::*;
();

  // op code the block treats as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int HOLD_CYCLES    = 1500;  // long result stall
  localparam int WATCHDOG_LIMIT = 20000; // cycles without any handshake
  localparam int DRAIN_CYCLES   = 300;   // outlasts the worst-case record
  localparam int HIST_DEPTH     = 64;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_valid;
  logic                  s_ready;
  logic [151:0]          s_data;
  logic [1:0]            s_user;
  logic                  m_valid;
  logic                  m_ready;
  logic [151:0]          m_data;
  logic [2:0]            m_user;
  int                    errors;
  int                    outstanding;

  // stimulus knobs shared with the receiver process
  bit   quiet    = 1'b0;  // no idling at all
  bit   hold_req = 1'b0;  // ask the receiver for the long stall
  bit   hold_done = 1'b0;

  // recent record words, replayed to provoke duplicates
  logic [63:0] hist_key  [HIST_DEPTH];
  logic [63:0] hist_addr [HIST_DEPTH];
  int          hist_n  = 0;
  int          hist_wr = 0;
  logic [7:0]  cur_code = '0;  // shadow of the trusted region code

  int idle_cnt = 0;

  dedup_fifo_event_log i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  dfl_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_valid),
    .s_tready_i    (s_ready),
    .s_tdata_i     (s_data),
    .s_tuser_i     (s_user),
    .m_tvalid_i    (m_valid),
    .m_tready_i    (m_ready),
    .m_tdata_i     (m_data),
    .m_tuser_i     (m_user),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result receiver: random ready bursts, one long hold-off on request
  initial begin : rx_proc
    int n;
    m_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        // block fills up behind this while the sender keeps offering
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        m_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        m_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one command word; valid stays high into the next word unless a gap falls
  task automatic send_word(input logic [1:0] op, input logic [63:0] key,
                           input logic [63:0] addr, input logic [7:0] cls,
                           input logic trusted, input logic [7:0] pos);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    // name_key, event_address, region_class, in_trusted_code, read_position
    s_data  <= {7'd0, pos, trusted, cls, addr, key};
    do @(posedge clk); while (!s_ready);
  endtask

  // stop offering and wait until every result has come back
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TRUSTED) cur_code = data;
    @(posedge clk);
  endtask

  // enable only looks at bit 0, the upper bits are random noise
  task automatic set_enable(input logic en);
    cfg_write(REG_ENABLE, {7'($urandom), en});
  endtask

  task automatic random_command();
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] addr;
    logic [7:0]  cls;
    logic [7:0]  pos;
    logic        trusted;
    int          sel;
    int          pick;
    sel = $urandom_range(0, 999);
    if (sel < 1) op = OP_CLEAR;
    else if (sel < 11) op = OP_UNUSED;
    else if (sel < 290) op = OP_READ;
    else op = OP_RECORD;
    key  = rand64();
    addr = rand64();
    // replay a recent pair, or its key with a new address
    sel = $urandom_range(0, 9);
    if (hist_n > 0 && sel < 3) begin
      pick = $urandom_range(0, hist_n - 1);
      key  = hist_key[pick];
      if (sel < 2) addr = hist_addr[pick];
    end
    cls     = ($urandom_range(0, 7) == 0) ? cur_code : 8'($urandom);
    trusted = ($urandom_range(0, 9) == 0);
    pos     = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 31));
    if (op == OP_RECORD) begin
      hist_key[hist_wr]  = key;
      hist_addr[hist_wr] = addr;
      hist_wr = (hist_wr + 1) % HIST_DEPTH;
      if (hist_n < HIST_DEPTH) hist_n++;
    end
    send_word(op, key, addr, cls, trusted, pos);
  endtask

  task automatic run_random(input int n);
    repeat (n) random_command();
  endtask

  initial begin : stim_proc
    logic [63:0] ones;
    ones = '1;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_user    <= OP_RECORD;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disarmed after reset
    send_word(OP_RECORD, ones, ones, 8'h5a, 1'b0, 8'h00);
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h00);  // empty, out of range
    send_word(OP_UNUSED, '0,   '0,   8'h00, 1'b0, 8'h00);
    send_word(OP_CLEAR,  '0,   '0,   8'h00, 1'b0, 8'h00);
    wait_drained();

    cfg_write(REG_TRUSTED, 8'hff);
    set_enable(1'b1);
    send_word(OP_RECORD, ones, ones, 8'h00, 1'b0, 8'h00);  // inserted
    send_word(OP_RECORD, ones, ones, 8'h00, 1'b0, 8'h00);  // duplicate
    send_word(OP_RECORD, '0,   '0,   8'hff, 1'b0, 8'h00);  // class filter
    send_word(OP_RECORD, '0,   '0,   8'hff, 1'b1, 8'h00);  // class beats trusted
    send_word(OP_RECORD, '0,   '0,   8'h00, 1'b1, 8'h00);  // trusted filter
    send_word(OP_RECORD, '0,   '0,   8'hfe, 1'b0, 8'h00);
    send_word(OP_RECORD, ones, '0,   8'h01, 1'b0, 8'h00);  // same key, new address
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h00);
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h02);
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h03);  // one past the end
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'hff);
    send_word(OP_UNUSED, ones, ones, 8'hff, 1'b1, 8'hff);  // must not touch state
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h01);
    wait_drained();

    // enable while already armed keeps the contents
    set_enable(1'b1);
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h02);
    wait_drained();
    set_enable(1'b0);
    send_word(OP_RECORD, rand64(), rand64(), 8'h10, 1'b0, 8'h00);
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h00);  // disarm keeps contents
    wait_drained();
    // arming empties the log
    set_enable(1'b1);
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h00);
    send_word(OP_RECORD, ones, ones, 8'h00, 1'b0, 8'h00);
    send_word(OP_CLEAR,  '0,   '0,   8'h00, 1'b0, 8'h00);
    send_word(OP_READ,   '0,   '0,   8'h00, 1'b0, 8'h00);
    send_word(OP_RECORD, ones, ones, 8'h00, 1'b0, 8'h00);  // not a duplicate now
    wait_drained();

    // random phase with trusted code zero, log fills and wraps
    cfg_write(REG_TRUSTED, 8'h00);
    run_random(600);
    wait_drained();

    // top trusted code
    cfg_write(REG_TRUSTED, 8'hff);
    run_random(500);
    wait_drained();

    // disarmed stretch with a random code
    set_enable(1'b0);
    cfg_write(REG_TRUSTED, 8'($urandom));
    run_random(60);
    wait_drained();

    // re-armed, long result stall in the middle, quiet tail
    set_enable(1'b1);
    cfg_write(REG_TRUSTED, 8'($urandom));
    run_random(200);
    hold_req = 1'b1;
    run_random(350);
    quiet = 1'b1;
    run_random(150);
    wait_drained();

    // let any stray word show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dfl_pkg.sv
hdl/dfl_ram.sv
hdl/dfl_ctrl.sv
hdl/dedup_fifo_event_log.sv
tb/sv/dfl_checker.sv
tb/sv/testbench.sv
